>>> sv/rfp_pkg.sv
`default_nettype none

package rfp_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [31:0] MIN_FRAME = 32'd26;

  // parse phases of one frame
  typedef enum logic [10:0] {
    PH_START   = 11'b000_0000_0001,
    PH_PKLEN   = 11'b000_0000_0010,
    PH_REQLEN  = 11'b000_0000_0100,
    PH_REQ     = 11'b000_0000_1000,
    PH_SVCLEN  = 11'b000_0001_0000,
    PH_SVC     = 11'b000_0010_0000,
    PH_ERR     = 11'b000_0100_0000,
    PH_INFOLEN = 11'b000_1000_0000,
    PH_INFO    = 11'b001_0000_0000,
    PH_PAYLOAD = 11'b010_0000_0000,
    PH_TRAILER = 11'b100_0000_0000
  } phase_e;

  // field tags
  localparam logic [2:0] FID_HDR     = 3'd0;
  localparam logic [2:0] FID_REQ     = 3'd1;
  localparam logic [2:0] FID_SVC     = 3'd2;
  localparam logic [2:0] FID_INFO    = 3'd3;
  localparam logic [2:0] FID_PAYLOAD = 3'd4;

  // frame status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_BAD_SOF  = 3'd2;
  localparam logic [2:0] ST_LEN_MISM = 3'd3;
  localparam logic [2:0] ST_OVERRUN  = 3'd4;
  localparam logic [2:0] ST_CRC_BAD  = 3'd5;
  localparam logic [2:0] ST_BAD_EOF  = 3'd6;

  // configuration register indexes
  localparam logic REG_START_MARKER = 1'b0;
  localparam logic REG_END_MARKER   = 1'b1;

  localparam logic [7:0] START_MARKER_RST = 8'h02;
  localparam logic [7:0] END_MARKER_RST   = 8'h03;

endpackage

`default_nettype wire

>>> sv/rfp_if.sv
`default_nettype none

interface rfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_last;

  modport source (output valid, output in_byte, output frame_last, input ready);
  modport sink   (input valid, input in_byte, input frame_last, output ready);
endinterface

interface rfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  field_id;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        frame_done;
  logic [2:0]  frame_status;
  logic [31:0] error_code_out;

  modport source (
    output valid, output field_id, output payload_byte, output payload_valid,
    output frame_done, output frame_status, output error_code_out, input ready
  );
  modport sink (
    input valid, input field_id, input payload_byte, input payload_valid,
    input frame_done, input frame_status, input error_code_out, output ready
  );
endinterface

`default_nettype wire

>>> sv/rfp_crc.sv
`default_nettype none

// One byte of a reflected CRC-32 update, bit by bit.
module rfp_crc (
  input  wire logic [31:0] crc_i,
  input  wire logic [7:0]  data_i,
  output logic      [31:0] crc_o
);
  import rfp_pkg::*;

  logic [31:0] c;

  always_comb begin
    c = crc_i ^ {24'd0, data_i};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    crc_o = c;
  end

endmodule

`default_nettype wire

>>> sv/rpc_frame_parser_crc32_unit.sv
// An accepted byte is held in the output register before it shows on the output port.
// Throughput: one word per cycle while out_o.ready is high; the output register frees
// as it is taken, so input and output may both move in the same cycle.
// Reset (rst_ni low, asynchronous) empties the output register, returns the parser
// to the start phase and loads the markers with 0x02 and 0x03.
`default_nettype none

module rpc_frame_parser_crc32_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rfp_in_if.sink           in_i,
  rfp_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import rfp_pkg::*;

  // ---------------- configuration ----------------
  logic [7:0] start_marker_q, end_marker_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = {24'd0, (paddr[2] == REG_END_MARKER) ? end_marker_q : start_marker_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= START_MARKER_RST;
      end_marker_q   <= END_MARKER_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_START_MARKER: start_marker_q <= pwdata[7:0];
        REG_END_MARKER:   end_marker_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------- parser state ----------------
  phase_e      phase_q, phase_d;
  logic [31:0] count_q, count_d;
  logic [31:0] decl_q, decl_d;
  logic [31:0] rem_q, rem_d;
  logic [23:0] word_q, word_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] rx_crc_q, rx_crc_d;
  logic [31:0] err_q, err_d;
  logic        start_bad_q, start_bad_d;
  logic        overrun_q, overrun_d;
  logic        end_ok_q, end_ok_d;

  logic        in_fire;
  logic        out_valid_q;
  logic [7:0]  b;
  logic [31:0] w;
  logic [31:0] rem_dec;
  logic [31:0] crc_next;
  logic [33:0] idx_p5, idx_p1, total, total_d;
  logic        crc_en, is_trailer, idx_zero;
  logic [2:0]  fid, status;
  logic        pvalid;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;
  assign w          = {word_q, b};
  assign rem_dec    = (rem_q != 32'd0) ? rem_q - 32'd1 : 32'd0;
  assign idx_p5     = {2'b00, count_q} + 34'd5;
  assign idx_p1     = {2'b00, count_q} + 34'd1;
  assign total      = {2'b00, decl_q} + 34'd2;
  assign idx_zero   = (count_q == 32'd0);
  assign crc_en     = !idx_zero && ((count_q < 32'd5) || (idx_p5 < total));
  assign is_trailer = (count_q >= 32'd5) && (idx_p5 >= total);

  rfp_crc u_crc (
    .crc_i  (crc_q),
    .data_i (b),
    .crc_o  (crc_next)
  );

  always_comb begin
    phase_d     = phase_q;
    decl_d      = decl_q;
    rem_d       = rem_q;
    word_d      = word_q;
    rx_crc_d    = rx_crc_q;
    err_d       = err_q;
    start_bad_d = start_bad_q;
    overrun_d   = overrun_q;
    end_ok_d    = end_ok_q;
    fid         = FID_HDR;
    pvalid      = 1'b0;
    count_d     = (count_q != 32'hFFFF_FFFF) ? count_q + 32'd1 : count_q;
    crc_d       = crc_en ? crc_next : crc_q;

    if (idx_zero) begin
      start_bad_d = (b != start_marker_q);
      phase_d     = PH_PKLEN;
      rem_d       = 32'd4;
      word_d      = 24'd0;
    end else if (is_trailer) begin
      if (phase_q != PH_PAYLOAD && phase_q != PH_TRAILER) begin
        overrun_d = 1'b1;
      end
      phase_d = PH_TRAILER;
      if (idx_p1 < total) begin
        rx_crc_d = {rx_crc_q[23:0], b};
      end else if (idx_p1 == total) begin
        end_ok_d = (b == end_marker_q);
      end
    end else begin
      unique case (phase_q) inside
        PH_PKLEN, PH_REQLEN, PH_SVCLEN, PH_ERR, PH_INFOLEN: begin
          word_d = w[23:0];
          rem_d  = rem_dec;
          if (rem_dec == 32'd0) begin
            word_d = 24'd0;
            if (phase_q == PH_PKLEN) begin
              decl_d  = w;
              phase_d = PH_REQLEN;
              rem_d   = 32'd4;
            end else if (phase_q == PH_REQLEN) begin
              // an empty field skips straight to the next length word
              phase_d = (w == 32'd0) ? PH_SVCLEN : PH_REQ;
              rem_d   = (w == 32'd0) ? 32'd4 : w;
            end else if (phase_q == PH_SVCLEN) begin
              phase_d = (w == 32'd0) ? PH_ERR : PH_SVC;
              rem_d   = (w == 32'd0) ? 32'd4 : w;
            end else if (phase_q == PH_ERR) begin
              err_d   = w;
              phase_d = PH_INFOLEN;
              rem_d   = 32'd4;
            end else begin
              phase_d = (w == 32'd0) ? PH_PAYLOAD : PH_INFO;
              rem_d   = w;
            end
          end
        end
        PH_REQ, PH_SVC, PH_INFO: begin
          fid    = (phase_q == PH_REQ) ? FID_REQ : (phase_q == PH_SVC) ? FID_SVC : FID_INFO;
          pvalid = 1'b1;
          rem_d  = rem_dec;
          if (rem_dec == 32'd0) begin
            word_d = 24'd0;
            if (phase_q == PH_REQ) begin
              phase_d = PH_SVCLEN;
              rem_d   = 32'd4;
            end else if (phase_q == PH_SVC) begin
              phase_d = PH_ERR;
              rem_d   = 32'd4;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          fid    = FID_PAYLOAD;
          pvalid = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // close-out status, first failing check wins
  assign total_d = {2'b00, decl_d} + 34'd2;

  always_comb begin
    if (count_d < MIN_FRAME) begin
      status = ST_SHORT;
    end else if (start_bad_d) begin
      status = ST_BAD_SOF;
    end else if (total_d != {2'b00, count_d}) begin
      status = ST_LEN_MISM;
    end else if (overrun_d) begin
      status = ST_OVERRUN;
    end else if ((crc_d ^ CRC_INIT) != rx_crc_d) begin
      status = ST_CRC_BAD;
    end else if (!end_ok_d) begin
      status = ST_BAD_EOF;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      count_q     <= 32'd0;
      decl_q      <= 32'd0;
      rem_q       <= 32'd0;
      word_q      <= 24'd0;
      crc_q       <= CRC_INIT;
      rx_crc_q    <= 32'd0;
      err_q       <= 32'd0;
      start_bad_q <= 1'b0;
      overrun_q   <= 1'b0;
      end_ok_q    <= 1'b0;
    end else if (in_fire) begin
      if (in_i.frame_last) begin
        // drop everything and wait for the next start word
        phase_q     <= PH_START;
        count_q     <= 32'd0;
        decl_q      <= 32'd0;
        rem_q       <= 32'd0;
        word_q      <= 24'd0;
        crc_q       <= CRC_INIT;
        rx_crc_q    <= 32'd0;
        err_q       <= 32'd0;
        start_bad_q <= 1'b0;
        overrun_q   <= 1'b0;
        end_ok_q    <= 1'b0;
      end else begin
        phase_q     <= phase_d;
        count_q     <= count_d;
        decl_q      <= decl_d;
        rem_q       <= rem_d;
        word_q      <= word_d;
        crc_q       <= crc_d;
        rx_crc_q    <= rx_crc_d;
        err_q       <= err_d;
        start_bad_q <= start_bad_d;
        overrun_q   <= overrun_d;
        end_ok_q    <= end_ok_d;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_o.field_id       <= fid;
      out_o.payload_byte   <= pvalid ? b : 8'd0;
      out_o.payload_valid  <= pvalid;
      out_o.frame_done     <= in_i.frame_last;
      out_o.frame_status   <= in_i.frame_last ? status : ST_OK;
      out_o.error_code_out <= in_i.frame_last ? err_d : 32'd0;
    end
  end

  assign out_o.valid = out_valid_q;

  // ---------------- assertions ----------------
  a_tag_on_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_o.payload_valid |-> out_o.field_id != FID_HDR)
    else $error("payload word tagged as header");

  a_quiet_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.frame_done |->
      out_o.frame_status == ST_OK && out_o.error_code_out == 32'd0)
    else $error("status or error code shown before frame end");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.frame_last |=> count_q == 32'd0 && crc_q == CRC_INIT)
    else $error("frame state not cleared after last word");

  a_first_word_leaves_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_i.frame_last && phase_q == PH_START |=> phase_q == PH_PKLEN)
    else $error("start word did not advance to length phase");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_i.frame_last && count_q != 32'hFFFF_FFFF |=>
      count_q == $past(count_q) + 32'd1)
    else $error("byte counter out of step");

endmodule

`default_nettype wire

>>> test/rfp_checker.sv
package rfp_tb_pkg;
  import rfp_pkg::*;

  // one byte of the reflected CRC-32, bit by bit
  function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

module rfp_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rfp_in_if                in_i,
  rfp_out_if               out_i,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int               mismatch_cnt_o,
  output int               results_owed_o
);
  import rfp_pkg::*;
  import rfp_tb_pkg::*;

  typedef struct packed {
    logic [2:0]  field_id;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        frame_done;
    logic [2:0]  frame_status;
    logic [31:0] error_code;
  } parse_res_t;

  parse_res_t  parse_results_q[$];

  logic [7:0]  start_mk, end_mk;
  phase_e      phase;
  logic [31:0] byte_cnt, decl_len, remaining, shift_w, crc_acc, rx_crc, ecode_held;
  logic        sof_bad, overrun, eof_ok;

  function automatic void restart_frame();
    phase      = PH_START;
    byte_cnt   = '0;
    decl_len   = '0;
    remaining  = '0;
    shift_w    = '0;
    crc_acc    = CRC_INIT;
    rx_crc     = '0;
    ecode_held = '0;
    sof_bad    = 1'b0;
    overrun    = 1'b0;
    eof_ok     = 1'b0;
  endfunction

  // a zero length skips the field body
  function automatic void enter_field(input phase_e body, input phase_e next,
                                      input logic [31:0] len);
    shift_w = '0;
    if (len == 0) begin
      phase     = next;
      remaining = (next == PH_PAYLOAD) ? 32'd0 : 32'd4;
    end else begin
      phase     = body;
      remaining = len;
    end
  endfunction

  function automatic parse_res_t parse_byte(input logic [7:0] b, input logic last);
    parse_res_t  r;
    logic [33:0] idx, total, n;
    logic [31:0] w;
    r     = '0;
    idx   = {2'b00, byte_cnt};
    total = {2'b00, decl_len} + 34'd2;
    if (byte_cnt != '1) byte_cnt = byte_cnt + 32'd1;
    n = {2'b00, byte_cnt};
    w = {shift_w[23:0], b};

    if (idx >= 1 && (idx < 5 || idx + 5 < total)) crc_acc = crc32_next(crc_acc, b);

    if (idx == 0) begin
      sof_bad   = (b != start_mk);
      phase     = PH_PKLEN;
      remaining = 32'd4;
      shift_w   = '0;
    end else if (idx >= 5 && idx + 5 >= total) begin
      // trailer: flag fields that never finished
      if (phase != PH_PAYLOAD && phase != PH_TRAILER) overrun = 1'b1;
      phase = PH_TRAILER;
      if (idx + 1 < total) rx_crc = {rx_crc[23:0], b};
      else if (idx + 1 == total) eof_ok = (b == end_mk);
    end else begin
      case (phase) inside
        PH_PKLEN, PH_REQLEN, PH_SVCLEN, PH_ERR, PH_INFOLEN: begin
          shift_w = w;
          if (remaining != 0) remaining = remaining - 32'd1;
          if (remaining == 0) begin
            case (phase)
              PH_PKLEN: begin
                decl_len  = w;
                phase     = PH_REQLEN;
                remaining = 32'd4;
                shift_w   = '0;
              end
              PH_REQLEN: enter_field(PH_REQ, PH_SVCLEN, w);
              PH_SVCLEN: enter_field(PH_SVC, PH_ERR, w);
              PH_ERR: begin
                ecode_held = w;
                phase      = PH_INFOLEN;
                remaining  = 32'd4;
                shift_w    = '0;
              end
              default: enter_field(PH_INFO, PH_PAYLOAD, w);
            endcase
          end
        end
        PH_REQ, PH_SVC, PH_INFO: begin
          r.field_id      = (phase == PH_REQ) ? FID_REQ : (phase == PH_SVC) ? FID_SVC : FID_INFO;
          r.payload_valid = 1'b1;
          r.payload_byte  = b;
          if (remaining != 0) remaining = remaining - 32'd1;
          if (remaining == 0) begin
            case (phase)
              PH_REQ: begin
                phase     = PH_SVCLEN;
                remaining = 32'd4;
              end
              PH_SVC: begin
                phase     = PH_ERR;
                remaining = 32'd4;
              end
              default: phase = PH_PAYLOAD;
            endcase
            shift_w = '0;
          end
        end
        PH_PAYLOAD: begin
          r.field_id      = FID_PAYLOAD;
          r.payload_valid = 1'b1;
          r.payload_byte  = b;
        end
        default: ;
      endcase
    end

    if (last) begin
      r.frame_done = 1'b1;
      total = {2'b00, decl_len} + 34'd2;
      if (n < MIN_FRAME) r.frame_status = ST_SHORT;
      else if (sof_bad) r.frame_status = ST_BAD_SOF;
      else if (total != n) r.frame_status = ST_LEN_MISM;
      else if (overrun) r.frame_status = ST_OVERRUN;
      else if ((crc_acc ^ CRC_INIT) != rx_crc) r.frame_status = ST_CRC_BAD;
      else if (!eof_ok) r.frame_status = ST_BAD_EOF;
      else r.frame_status = ST_OK;
      r.error_code = ecode_held;
      restart_frame();
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_cnt_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    parse_res_t want;
    if (!rst_ni) begin
      start_mk = START_MARKER_RST;
      end_mk   = END_MARKER_RST;
      restart_frame();
      parse_results_q.delete();
      mismatch_cnt_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_END_MARKER) end_mk = pwdata[7:0];
        else start_mk = pwdata[7:0];
      end
      // retire the oldest word first: a word entering now leaves next cycle at the earliest
      if (out_i.valid && out_i.ready) begin
        if (parse_results_q.size() == 0) begin
          $error("output word with no input word pending");
          mismatch_cnt_o++;
        end else begin
          want = parse_results_q.pop_front();
          check_field("field_id", want.field_id, out_i.field_id);
          check_field("payload_byte", want.payload_byte, out_i.payload_byte);
          check_field("payload_valid", want.payload_valid, out_i.payload_valid);
          check_field("frame_done", want.frame_done, out_i.frame_done);
          check_field("frame_status", want.frame_status, out_i.frame_status);
          check_field("error_code_out", want.error_code, out_i.error_code_out);
        end
      end
      if (in_i.valid && in_i.ready) begin
        parse_results_q.push_back(parse_byte(in_i.in_byte, in_i.frame_last));
      end
    end
    results_owed_o = parse_results_q.size();
  end

endmodule

>>> test/tb.sv
module tb;
  import rfp_pkg::*;
  import rfp_tb_pkg::*;

  localparam int ITEMS      = 1300;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYC   = 80;

  typedef enum int {
    FR_GOOD, FR_BAD_SOF, FR_BAD_LEN, FR_OVERRUN, FR_BAD_CRC,
    FR_BAD_EOF, FR_SHORT, FR_LONG, FR_NOISE
  } frame_kind_e;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  int          mismatch_cnt, results_owed, bytes_sent, idle_cycles;
  logic        hold_off;
  logic [7:0]  start_mk, end_mk;
  logic [7:0]  frame_q[$];

  rfp_in_if  in_w();
  rfp_out_if out_w();

  rpc_frame_parser_crc32_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_w),
    .out_o   (out_w),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rfp_checker u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_w),
    .out_i          (out_w),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_cnt_o (mismatch_cnt),
    .results_owed_o (results_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // mostly back to back, a few long gaps
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic int field_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
  endfunction

  function automatic void push_word(input logic [31:0] v);
    for (int i = 0; i < 4; i++) frame_q.push_back(v[31 - 8*i -: 8]);
  endfunction

  function automatic void push_random(input int len);
    for (int i = 0; i < len; i++) frame_q.push_back(8'($urandom()));
  endfunction

  task automatic reg_write(input logic idx, input logic [7:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last, input bit calm);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_w.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_w.valid      <= 1'b1;
    in_w.in_byte    <= b;
    in_w.frame_last <= last;
    do @(posedge clk_i); while (!in_w.ready);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_kind_e kind, input bit calm, input bit bare);
    logic [31:0] plen, crc, ecode, extra;
    int          nreq, nsvc, ninfo, npay, which, cut;
    nreq  = bare ? 0 : field_len();
    nsvc  = bare ? 0 : field_len();
    ninfo = bare ? 0 : field_len();
    npay  = bare ? 0 : $urandom_range(0, 10);
    ecode = (bare || $urandom_range(0, 3) == 0) ? {32{1'($urandom_range(0, 1))}} : $urandom();
    // overrun: one length word claims more bytes than the frame holds
    which = (kind == FR_OVERRUN) ? $urandom_range(0, 2) : 3;
    extra = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(1, 40);

    frame_q.delete();
    frame_q.push_back(start_mk);
    push_word(32'd0);
    push_word(nreq + (which == 0 ? extra : 0));
    push_random(nreq);
    push_word(nsvc + (which == 1 ? extra : 0));
    push_random(nsvc);
    push_word(ecode);
    push_word(ninfo + (which == 2 ? extra : 0));
    push_random(ninfo);
    push_random(npay);

    plen = frame_q.size() + 3;
    if (kind == FR_BAD_LEN) begin
      if ($urandom_range(0, 3) == 0) plen = $urandom();
      else if ($urandom_range(0, 1) == 0) plen = plen + $urandom_range(1, 3);
      else plen = plen - $urandom_range(1, 3);
    end
    for (int i = 0; i < 4; i++) frame_q[1 + i] = plen[31 - 8*i -: 8];

    crc = CRC_INIT;
    for (int i = 1; i < frame_q.size(); i++) crc = crc32_next(crc, frame_q[i]);
    crc = crc ^ CRC_INIT;
    if (kind == FR_BAD_CRC) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    push_word(crc);
    frame_q.push_back(kind == FR_BAD_EOF ? end_mk ^ 8'($urandom_range(1, 255)) : end_mk);

    if (kind == FR_BAD_SOF) frame_q[0] = frame_q[0] ^ 8'($urandom_range(1, 255));
    if (kind == FR_SHORT) begin
      cut = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
    if (kind == FR_LONG) push_random($urandom_range(1, 6));
    if (kind == FR_NOISE) begin
      frame_q.delete();
      push_random($urandom_range(1, 40));
    end

    for (int i = 0; i < frame_q.size(); i++) begin
      send_byte(frame_q[i], i == frame_q.size() - 1, calm);
    end
  endtask

  // change markers only with the parser drained
  task automatic set_markers(input logic [7:0] s, input logic [7:0] e);
    in_w.valid <= 1'b0;
    wait (results_owed == 0);
    repeat (2) @(posedge clk_i);
    reg_write(REG_START_MARKER, s);
    reg_write(REG_END_MARKER, e);
    start_mk = s;
    end_mk   = e;
  endtask

  initial begin : rx_side
    int run;
    bit held;
    held        = 1'b0;
    out_w.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off && !held) begin
        // hold ready low long enough to back up the input
        held = 1'b1;
        out_w.ready <= 1'b0;
        repeat (HOLD_CYC - 1) @(negedge clk_i);
      end else if ($urandom_range(0, 9) < 7) begin
        out_w.ready <= 1'b1;
        run = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
        repeat (run) @(negedge clk_i);
      end else begin
        out_w.ready <= 1'b0;
        run = pick_gap();
        repeat (run) @(negedge clk_i);
      end
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("rpc_frame_parser_crc32_unit test failed");
    $finish;
  end

  initial begin : stim
    frame_kind_e kind;
    logic [7:0]  s;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_w.valid      = 1'b0;
    in_w.in_byte    = '0;
    in_w.frame_last = 1'b0;
    hold_off        = 1'b0;
    bytes_sent      = 0;
    start_mk        = START_MARKER_RST;
    end_mk          = END_MARKER_RST;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // lone byte, then the smallest legal frame with empty fields
    send_byte(8'hFF, 1'b1, 1'b1);
    send_frame(FR_GOOD, 1'b1, 1'b1);

    for (int p = 0; p < 5; p++) begin
      case (p)
        1: set_markers(8'h00, 8'hFF);
        2: begin
          set_markers(8'hFF, 8'h00);
          hold_off = 1'b1;
        end
        3: set_markers(8'($urandom()), 8'($urandom()));
        4: begin
          s = 8'($urandom());
          set_markers(s, s);
        end
        default: ;
      endcase
      while (bytes_sent < (p + 1) * ITEMS / 5) begin
        if ($urandom_range(0, 99) < 60) kind = FR_GOOD;
        else kind = frame_kind_e'($urandom_range(1, 8));
        send_frame(kind, $urandom_range(0, 3) == 0, 1'b0);
      end
    end

    in_w.valid <= 1'b0;
    wait (results_owed == 0);
    repeat (4) @(posedge clk_i);
    if (mismatch_cnt == 0 && results_owed == 0) begin
      $display("rpc_frame_parser_crc32_unit test passed");
    end else begin
      $display("rpc_frame_parser_crc32_unit test failed");
    end
    $finish;
  end

endmodule
